FILE: rtl/core/abst_pkg.sv
`default_nettype none

package abst_pkg;

    // tree geometry
    localparam int CAPACITY    = 15;
    localparam int MAX_RESULTS = 15;
    localparam int VALUE_W     = 32;
    localparam int SLOT_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int IDX_W       = $clog2(2 * CAPACITY + 1);
    localparam int KEY_W       = $clog2(CAPACITY + 1);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef enum logic {
        KIND_INSERT  = 1'b0,
        KIND_READOUT = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_ELEMENT  = 2'd2
    } t_status;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] result_value;
        logic                      last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RD_ROOT,
        RD_CHILD,
        RD_NODE
    } t_rd_sel;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    start_read;
        logic    walk_step;
        logic    do_insert;
        logic    emit_no_room;
        logic    latch_node;
        logic    emit_elem;
        logic    key_next;
        logic    rd_en;
        t_rd_sel rd_sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic kind;
        logic idx_oob;
        logic idx_used;
        logic node_hit;
        logic fill_zero;
        logic elem_last;
        logic out_free;
    } t_stat;

    // heap slot at in-order rank key-1 of a complete tree with KEY_W levels
    function automatic logic [KEY_W-1:0] inorder_node(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] n;
        int               tz;
        logic             found;
        tz    = 0;
        found = 1'b0;
        for (int b = 0; b < KEY_W; b++) begin
            if (!found) begin
                if (key[b]) begin
                    found = 1'b1;
                end else begin
                    tz = tz + 1;
                end
            end
        end
        n = (KEY_W'(1) << (KEY_W - 1 - tz)) | (key >> (tz + 1));
        return n - KEY_W'(1);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/abst_ctrl.sv
`default_nettype none

module abst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire abst_pkg::t_stat i_stat,
    output abst_pkg::t_cmd     o_cmd
);
    import abst_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_sel = RD_ROOT;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ROOT;
                    if (i_stat.kind == KIND_INSERT) begin
                        n_state = S_WALK;
                    end else begin
                        o_cmd.start_read = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_WALK: begin
                if (i_stat.idx_oob) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_no_room = 1'b1;
                        n_state            = S_IDLE;
                    end
                end else if (!i_stat.idx_used) begin
                    if (i_stat.out_free) begin
                        o_cmd.do_insert = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.walk_step = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = RD_CHILD;
                end
            end
            S_SCAN: begin
                if (i_stat.fill_zero) begin
                    n_state = S_IDLE;
                end else if (i_stat.node_hit) begin
                    o_cmd.rd_en      = 1'b1;
                    o_cmd.rd_sel     = RD_NODE;
                    o_cmd.latch_node = 1'b1;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.key_next = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_elem = 1'b1;
                    if (i_stat.elem_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.key_next = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/abst_dp.sv
`default_nettype none

module abst_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire abst_pkg::t_in_item i_in,
    input  wire abst_pkg::t_cmd     i_cmd,
    output abst_pkg::t_stat         o_stat,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output abst_pkg::t_out_item     o_out
);
    import abst_pkg::*;

    logic [VALUE_W-1:0]        r_mem [CAPACITY];
    logic [CAPACITY-1:0]       r_used;
    logic [CNT_W-1:0]          r_fill;
    logic [CNT_W-1:0]          r_count;
    logic [IDX_W-1:0]          r_idx;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] r_rdata;
    logic [KEY_W-1:0]          r_key;
    logic [ADDR_W-1:0]         r_node;
    t_out_item                 r_out;
    logic                      r_out_valid;

    logic                      idx_in;
    logic [ADDR_W-1:0]         idx_addr;
    logic                      go_left;
    logic [IDX_W-1:0]          child;
    logic [KEY_W-1:0]          node_full;
    logic                      node_in;
    logic [ADDR_W-1:0]         node_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      out_free;
    logic [CNT_W:0]            count_p1;
    logic                      load_out;

    // descent: bound check first, then used mark and compare
    assign idx_in   = r_idx < IDX_W'(CAPACITY);
    assign idx_addr = r_idx[ADDR_W-1:0];
    assign go_left  = r_value <= r_rdata;
    assign child    = {r_idx[IDX_W-2:0], 1'b0} + (go_left ? IDX_W'(1) : IDX_W'(2));

    // readout: next slot in in-order rank
    assign node_full = inorder_node(r_key);
    assign node_in   = node_full < KEY_W'(CAPACITY);
    assign node_addr = node_full[ADDR_W-1:0];

    assign out_free = !r_out_valid || i_out_ready;
    assign count_p1 = {1'b0, r_count} + (CNT_W + 1)'(1);

    always_comb begin
        o_stat.kind      = i_in.kind;
        o_stat.idx_oob   = !idx_in;
        o_stat.idx_used  = idx_in ? r_used[idx_addr] : 1'b0;
        o_stat.node_hit  = node_in ? r_used[node_addr] : 1'b0;
        o_stat.fill_zero = r_fill == '0;
        o_stat.elem_last = (count_p1 == {1'b0, r_fill})
                        || (32'(count_p1) == 32'(MAX_RESULTS));
        o_stat.out_free  = out_free;
    end

    // read address select
    always_comb begin
        case (i_cmd.rd_sel)
            RD_ROOT:  rd_addr = '0;
            RD_CHILD: rd_addr = child[ADDR_W-1:0];
            RD_NODE:  rd_addr = node_addr;
            default:  rd_addr = '0;
        endcase
    end

    // value memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_insert) begin
            r_mem[idx_addr] <= r_value;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // occupancy marks and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_fill <= '0;
        end else if (i_cmd.do_insert) begin
            r_used[idx_addr] <= 1'b1;
            r_fill           <= r_fill + CNT_W'(1);
        end
    end

    // walk and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_in.value;
            r_idx   <= '0;
        end else if (i_cmd.walk_step) begin
            r_idx <= child;
        end
        if (i_cmd.start_read) begin
            r_key   <= KEY_W'(1);
            r_count <= '0;
        end else begin
            if (i_cmd.key_next) begin
                r_key <= r_key + KEY_W'(1);
            end
            if (i_cmd.emit_elem) begin
                r_count <= count_p1[CNT_W-1:0];
            end
        end
        if (i_cmd.latch_node) begin
            r_node <= node_addr;
        end
    end

    // output register
    assign load_out = i_cmd.do_insert || i_cmd.emit_no_room || i_cmd.emit_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_insert) begin
            r_out.status       <= ST_INSERTED;
            r_out.slot         <= SLOT_W'(r_idx);
            r_out.result_value <= r_value;
            r_out.last         <= 1'b1;
        end else if (i_cmd.emit_no_room) begin
            r_out.status       <= ST_NO_ROOM;
            r_out.slot         <= '0;
            r_out.result_value <= r_value;
            r_out.last         <= 1'b1;
        end else if (i_cmd.emit_elem) begin
            r_out.status       <= ST_ELEMENT;
            r_out.slot         <= SLOT_W'(r_node);
            r_out.result_value <= r_rdata;
            r_out.last         <= o_stat.elem_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/array_bst_insert_and_inorder_unit.sv
// Binary search tree held in a 15-slot array (children of slot i at 2i+1, 2i+2).
// Input channel i_in (kind, value) with i_in_valid / o_in_ready; result channel
// o_out (status, slot, result_value, last) with o_out_valid / i_out_ready.
// An insert beat walks from the root, one tree level per cycle, reading one
// slot of the value memory per level, and gives one result beat: inserted at
// the free slot found, or no room when the path leaves the array.
// A readout beat gives every stored value smallest first, the final one
// marked last; an empty tree gives nothing. The scan visits slots in in-order
// rank, one per cycle; each stored value found takes an extra emit step, which
// holds until the output register is free.
// One input beat is worked at a time; o_in_ready is high when the block is
// free, and the next beat is taken while the previous result still sits in
// the output register. When the receiver stalls, the walk holds at its last
// step until the output register frees.
// Synchronous reset empties the tree: all occupancy marks clear at once, no
// clearing pass. The stored values themselves are not reset.
`default_nettype none

module array_bst_insert_and_inorder_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire abst_pkg::t_in_item i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output abst_pkg::t_out_item     o_out
);
    import abst_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    abst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // tree storage, walk registers and output register
    abst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: tb/sv/array_bst_insert_and_inorder_unit_tb.sv
`timescale 1ns / 1ps

module array_bst_insert_and_inorder_unit_tb;
    import abst_pkg::*;

    localparam int N_RANDOM     = 480;
    localparam int N_ROWS       = 23;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fff_ffff;

    // one directed beat; a checked-by-hand row carries its result inline
    typedef struct {
        t_kind                     kind;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        t_status                   st;
        logic [SLOT_W-1:0]         slot;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    // shadow copy of the tree
    logic signed [VALUE_W-1:0] tree_value [CAPACITY];
    logic                      tree_used  [CAPACITY];

    t_out_item outcomes[$];
    t_out_item awaited_results[$];
    t_row      dir_rows [N_ROWS];

    int errors     = 0;
    int stall_left = 0;
    bit recv_quiet = 1'b0;

    array_bst_insert_and_inorder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // apply one beat to the shadow tree and collect the results it causes
    task automatic bst_apply(input t_in_item item);
        int                        idx;
        int                        trail[$];
        logic signed [VALUE_W-1:0] v;
        t_out_item                 r;
        outcomes.delete();
        v = item.value;
        if (item.kind == KIND_INSERT) begin
            idx = 0;
            r = '{ST_NO_ROOM, 4'd0, v, 1'b1};
            // descend until a free slot or off the array
            while (idx < CAPACITY) begin
                if (!tree_used[idx]) begin
                    tree_value[idx] = v;
                    tree_used[idx]  = 1'b1;
                    r = '{ST_INSERTED, SLOT_W'(idx), v, 1'b1};
                    break;
                end
                idx = (v <= tree_value[idx]) ? 2 * idx + 1 : 2 * idx + 2;
            end
            outcomes.push_back(r);
        end else begin
            // iterative in-order walk with an explicit stack
            idx = 0;
            while ((idx < CAPACITY && tree_used[idx]) || trail.size() > 0) begin
                if (idx < CAPACITY && tree_used[idx]) begin
                    trail.push_back(idx);
                    idx = 2 * idx + 1;
                end else begin
                    idx = trail.pop_back();
                    if (outcomes.size() < MAX_RESULTS) begin
                        outcomes.push_back('{ST_ELEMENT, SLOT_W'(idx), tree_value[idx], 1'b0});
                    end
                    idx = 2 * idx + 2;
                end
            end
            if (outcomes.size() > 0) begin
                r = outcomes.pop_back();
                r.last = 1'b1;
                outcomes.push_back(r);
            end
        end
    endtask

    // mostly short gaps, a few long ones, none in a quiet stretch
    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // insert values: neighbors of stored keys hit the compare boundary
    function automatic logic [VALUE_W-1:0] pick_value();
        int                 s;
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 4))
            0: begin
                s = $urandom_range(0, CAPACITY - 1);
                if (tree_used[s]) begin
                    v = tree_value[s] + VALUE_W'($urandom_range(0, 2)) - VALUE_W'(1);
                end else begin
                    v = $urandom;
                end
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: v = V_MIN;
                    1: v = V_MAX;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            2: v = VALUE_W'($urandom_range(0, 4000)) - VALUE_W'(2000);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // drive one input beat at the falling edge and hold it until taken
    task automatic send_beat(input t_kind kind, input logic [VALUE_W-1:0] value,
                             input bit typed, input t_out_item typed_res,
                             input int gap);
        t_in_item item;
        item = '{kind, value};
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        bst_apply(item);
        if (typed) begin
            // a hand-checked readout row means an empty tree: nothing due
            if (kind == KIND_INSERT) awaited_results.push_back(typed_res);
        end else begin
            foreach (outcomes[k]) awaited_results.push_back(outcomes[k]);
        end
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin : stimulus
        t_out_item typed_res;
        bit        send_quiet;
        t_kind     kind;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        send_quiet  = 1'b0;
        foreach (tree_used[k]) tree_used[k] = 1'b0;
        dir_rows = '{
            '{KIND_READOUT, 32'sd0,        1'b1, ST_ELEMENT,  4'd0},
            '{KIND_INSERT,  32'sd0,        1'b1, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  -32'sd1000,    1'b0, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  32'sd1000,     1'b0, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  V_MIN,         1'b1, ST_INSERTED, 4'd3},
            '{KIND_INSERT,  -32'sd500,     1'b0, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  32'sd500,      1'b0, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  32'sd2000,     1'b0, ST_INSERTED, 4'd0},
            '{KIND_READOUT, 32'sh5555_5555, 1'b0, ST_ELEMENT, 4'd0},
            '{KIND_INSERT,  V_MIN,         1'b1, ST_INSERTED, 4'd7},
            '{KIND_INSERT,  -32'sd2000,    1'b0, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  -32'sd700,     1'b0, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  32'sd0,        1'b0, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  32'sd300,      1'b0, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  32'sd1000,     1'b0, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  32'sd1500,     1'b0, ST_INSERTED, 4'd0},
            '{KIND_INSERT,  V_MAX,         1'b1, ST_INSERTED, 4'd14},
            '{KIND_READOUT, 32'sd0,        1'b0, ST_ELEMENT,  4'd0},
            '{KIND_INSERT,  V_MAX,         1'b1, ST_NO_ROOM,  4'd0},
            '{KIND_INSERT,  V_MIN,         1'b1, ST_NO_ROOM,  4'd0},
            '{KIND_INSERT,  -32'sd1,       1'b0, ST_INSERTED, 4'd0},
            '{KIND_READOUT, V_MAX,         1'b0, ST_ELEMENT,  4'd0},
            '{KIND_READOUT, -32'sd1,       1'b0, ST_ELEMENT,  4'd0}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: builds a full tree with both extremes and duplicates
        foreach (dir_rows[n]) begin
            typed_res = '{dir_rows[n].st, dir_rows[n].slot, dir_rows[n].value, 1'b1};
            send_beat(dir_rows[n].kind, dir_rows[n].value, dir_rows[n].typed,
                      typed_res, pick_gap(send_quiet));
        end

        // random: mostly inserts, some full readouts
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
            kind = ($urandom_range(0, 4) == 0) ? KIND_READOUT : KIND_INSERT;
            send_beat(kind, (kind == KIND_INSERT) ? pick_value() : VALUE_W'($urandom),
                      1'b0, '0, pick_gap(send_quiet));
        end
        i_in_valid <= 1'b0;

        // drain
        while (awaited_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && awaited_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (stall_left == 0);
        end
    end

    // compare each result beat against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected beat: status %0d slot %0d value %0d last %0d",
                         $time, o_out.status, o_out.slot, o_out.result_value, o_out.last);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (o_out.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out.status);
                    errors++;
                end
                if (o_out.slot !== want.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, o_out.slot);
                    errors++;
                end
                if (o_out.result_value !== want.result_value) begin
                    $display("%0t: value expected %0d actual %0d",
                             $time, want.result_value, o_out.result_value);
                    errors++;
                end
                if (o_out.last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, want.last, o_out.last);
                    errors++;
                end
            end
            if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
            stall_left = pick_gap(recv_quiet);
        end else if (stall_left > 0) begin
            // count down the stall one cycle at a time
            stall_left = stall_left - 1;
        end
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
